// File: hdl/pktd_pkg.sv
// ----------------------------------------------------------------------------
// pktd_pkg
// Shared types and constants of the per-pixel Kalman temporal denoiser.
// ----------------------------------------------------------------------------
package pktd_pkg;

  localparam int MAX_PIXELS = 262144;
  localparam int POS_W      = 18;
  localparam int FP_W       = 19;
  localparam int NUM_CH     = 3;
  localparam int DIV_STEPS  = 9;
  // registers inside one channel datapath: diff, products, sum, divider, gain products
  localparam int CHAN_LAT   = 4 + DIV_STEPS;
  // input stage plus channel datapath
  localparam int PIPE_LEN   = 1 + CHAN_LAT;

  typedef enum logic [2:0] {
    REG_MIX         = 3'd0,
    REG_NOISE_BLUE  = 3'd1,
    REG_NOISE_GREEN = 3'd2,
    REG_NOISE_RED   = 3'd3,
    REG_FRAME_PIX   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [NUM_CH-1:0][7:0] est;
    logic [NUM_CH-1:0][7:0] vr;
  } pix_word_t;

  typedef struct packed {
    logic [POS_W-1:0]       pos;
    logic                   last;
    logic                   seed;
    logic [NUM_CH-1:0][7:0] meas;
  } meta_t;

endpackage

// File: hdl/pixel_kalman_temporal_denoise.sv
// ----------------------------------------------------------------------------
// pixel_kalman_temporal_denoise
// Per-pixel Kalman temporal filter on an RGB raster stream with frame stores.
// ----------------------------------------------------------------------------
// channel  handshake               payload
// in       in_valid / in_ready    in_blue, in_green, in_red, reinit
// out      out_valid / out_ready  out_blue, out_green, out_red, frame_end
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one pixel per cycle unless stalled, via input stage, channel datapath, output register.
// the pipeline moves as one: it stalls only while a result waits in the output register.
// a pixel whose position is still in flight (frames shorter than the pipeline) waits at
// the input until that position has been written back to the store.
// synchronous reset clears control and loads register defaults; stores are not cleared.
module pixel_kalman_temporal_denoise import pktd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_blue,
  input  logic [7:0]      in_green,
  input  logic [7:0]      in_red,
  input  logic            reinit,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_green,
  output logic [7:0]      out_red,
  output logic            frame_end,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [FP_W-1:0] cfg_data
);

  localparam logic [FP_W-1:0] MAX_LEN = FP_W'(MAX_PIXELS);

  logic [7:0]            mix;
  logic [NUM_CH-1:0][7:0] noise;
  logic [FP_W-1:0]       frame_pix;

  logic [POS_W-1:0]      pos;
  logic                  seeding;

  logic                  vld  [PIPE_LEN];
  meta_t                 meta [PIPE_LEN];

  pix_word_t             mem [MAX_PIXELS];
  pix_word_t             rdata;
  pix_word_t             wdata;

  logic                  adv;
  logic                  hazard;
  logic                  in_fire;
  logic                  seed_now;
  logic                  last_now;
  logic [FP_W-1:0]       len_m1;
  logic [NUM_CH-1:0][7:0] est_new;
  logic [NUM_CH-1:0][7:0] var_new;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix       <= 8'd26;
      noise     <= {NUM_CH{8'd64}};
      frame_pix <= MAX_LEN;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIX:         mix       <= cfg_data[7:0];
        REG_NOISE_BLUE:  noise[0]  <= cfg_data[7:0];
        REG_NOISE_GREEN: noise[1]  <= cfg_data[7:0];
        REG_NOISE_RED:   noise[2]  <= cfg_data[7:0];
        REG_FRAME_PIX:   frame_pix <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_pix == '0) begin
      len_m1 = '0;
    end else if (frame_pix > MAX_LEN) begin
      len_m1 = MAX_LEN - 1'b1;
    end else begin
      len_m1 = frame_pix - 1'b1;
    end
  end

  assign last_now = ({1'b0, pos} >= len_m1);
  assign seed_now = seeding | ((pos == '0) & reinit);

  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < PIPE_LEN; i++) begin
      if (vld[i] && (meta[i].pos == pos)) hazard = 1'b1;
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !hazard;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      seeding <= 1'b1;
    end else if (in_fire) begin
      if (last_now) begin
        pos     <= '0;
        seeding <= 1'b0;
      end else begin
        pos     <= pos + 1'b1;
        seeding <= seed_now;
      end
    end
  end

  // valid bits travel with the pixel metadata
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LEN; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_fire;
      for (int i = 1; i < PIPE_LEN; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta[0].pos  <= pos;
      meta[0].last <= last_now;
      meta[0].seed <= seed_now;
      meta[0].meas <= {in_red, in_green, in_blue};
      for (int i = 1; i < PIPE_LEN; i++) meta[i] <= meta[i-1];
    end
  end

  // frame store: read at accept, written back as the pixel leaves the pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      rdata <= mem[pos];
      if (vld[PIPE_LEN-1]) mem[meta[PIPE_LEN-1].pos] <= wdata;
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    pktd_chan u_chan (
      .clk     (clk),
      .en      (adv),
      .mix     (mix),
      .noise   (noise[c]),
      .meas    (meta[0].meas[c]),
      .est     (rdata.est[c]),
      .vari    (rdata.vr[c]),
      .est_new (est_new[c]),
      .var_new (var_new[c])
    );
  end

  always_comb begin
    if (meta[PIPE_LEN-1].seed) begin
      wdata.est = meta[PIPE_LEN-1].meas;
      wdata.vr  = noise;
    end else begin
      wdata.est = est_new;
      wdata.vr  = var_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_blue  <= wdata.est[0];
      out_green <= wdata.est[1];
      out_red   <= wdata.est[2];
      frame_end <= meta[PIPE_LEN-1].last;
    end
  end

  // the whole pipeline shifts by one on every advance
  a_shift: assert property (@(posedge clk) disable iff (rst)
    adv && vld[0] |=> vld[1])
    else $error("pipeline lost a pixel between stages");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("input taken while the output is blocked");

  a_reseed: assert property (@(posedge clk) disable iff (rst)
    in_fire && (pos == '0) && reinit |=> vld[0] && meta[0].seed)
    else $error("reinit at frame start did not start a seeding frame");

  a_last_wrap: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_now |=> (pos == '0) && !seeding)
    else $error("position did not wrap after the last pixel of a frame");

endmodule

// File: hdl/pktd_chan.sv
// ----------------------------------------------------------------------------
// pktd_chan
// One color channel of the Kalman update, pipelined with a shared stall enable.
// ----------------------------------------------------------------------------
module pktd_chan import pktd_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] mix,
  input  logic [7:0] noise,
  input  logic [7:0] meas,
  input  logic [7:0] est,
  input  logic [7:0] vari,
  output logic [7:0] est_new,
  output logic [7:0] var_new
);

  logic signed [8:0]  diff_w;
  logic [7:0]         absd_w;
  logic signed [8:0]  c1_diff;
  logic [15:0]        c1_sq;
  logic [7:0]         c1_est;
  logic [7:0]         c1_var;

  logic [16:0]        c2_pa;
  logic [23:0]        c2_pb;
  logic signed [8:0]  c2_diff;
  logic [7:0]         c2_est;

  logic [23:0]        vm_w;
  logic [24:0]        den_w;

  logic [31:0]        dv_rem  [DIV_STEPS+1];
  logic [24:0]        dv_den  [DIV_STEPS+1];
  logic [8:0]         dv_q    [DIV_STEPS+1];
  logic [23:0]        dv_vm   [DIV_STEPS+1];
  logic signed [8:0]  dv_diff [DIV_STEPS+1];
  logic [7:0]         dv_est  [DIV_STEPS+1];
  logic               dv_zero [DIV_STEPS+1];

  logic [8:0]         k_w;
  logic signed [18:0] c4_pk;
  logic [31:0]        c4_pv;
  logic [7:0]         c4_est;

  logic signed [19:0] ev;
  logic [32:0]        vv;

  assign diff_w = $signed({1'b0, meas}) - $signed({1'b0, est});
  assign absd_w = diff_w[8] ? 8'(-diff_w) : diff_w[7:0];

  always_ff @(posedge clk) begin
    if (en) begin
      c1_diff <= diff_w;
      c1_sq   <= 16'(absd_w * absd_w);
      c1_est  <= est;
      c1_var  <= vari;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_pa   <= 17'((9'd256 - {1'b0, mix}) * c1_var);
      c2_pb   <= 24'(mix * c1_sq);
      c2_diff <= c1_diff;
      c2_est  <= c1_est;
    end
  end

  assign vm_w  = {7'b0, c2_pa} + c2_pb;
  assign den_w = {1'b0, vm_w} + {9'b0, noise, 8'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0]  <= {vm_w, 8'b0};
      dv_den[0]  <= den_w;
      dv_q[0]    <= '0;
      dv_vm[0]   <= vm_w;
      dv_diff[0] <= c2_diff;
      dv_est[0]  <= c2_est;
      dv_zero[0] <= (den_w == '0);
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [33:0] sub;
    logic        fit;
    assign sub = {9'b0, dv_den[j]} << (DIV_STEPS - 1 - j);
    assign fit = ({2'b0, dv_rem[j]} >= sub);
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[j+1]  <= fit ? (dv_rem[j] - sub[31:0]) : dv_rem[j];
        dv_q[j+1]    <= {dv_q[j][7:0], fit};
        dv_den[j+1]  <= dv_den[j];
        dv_vm[j+1]   <= dv_vm[j];
        dv_diff[j+1] <= dv_diff[j];
        dv_est[j+1]  <= dv_est[j];
        dv_zero[j+1] <= dv_zero[j];
      end
    end
  end

  assign k_w = dv_zero[DIV_STEPS] ? 9'd0 : dv_q[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      c4_pk  <= 19'($signed({1'b0, k_w}) * dv_diff[DIV_STEPS]);
      c4_pv  <= 32'((10'd256 - {1'b0, k_w}) * dv_vm[DIV_STEPS][23:1]);
      c4_est <= dv_est[DIV_STEPS];
    end
  end

  assign ev = $signed({4'b0, c4_est, 8'b0}) + 20'(c4_pk) + 20'sd128;
  assign vv = {1'b0, c4_pv} + 33'd16384;

  always_comb begin
    if (ev[19]) begin
      est_new = 8'd0;
    end else if (ev[18:16] != 3'b0) begin
      est_new = 8'd255;
    end else begin
      est_new = ev[15:8];
    end
    if (vv[32:23] != 10'b0) begin
      var_new = 8'd255;
    end else begin
      var_new = vv[22:15];
    end
  end

endmodule
